// ===== rtl/rle_enc_pkg.sv =====
// ----------------------------------------------------------------------------
// rle_enc_pkg
// Shared constants for the run/literal byte-stream encoder.
// ----------------------------------------------------------------------------
package rle_enc_pkg;

    localparam int BYTE_W      = 8;
    localparam int LIT_MAX     = 32;    // literal group limit, 3..63
    localparam int RUN_MAX     = 127;   // run limit, 3..127
    localparam int CNT_W       = 6;     // literal count width
    localparam int RUN_W       = 7;     // run length width
    localparam int LIT_IDX_W   = $clog2(LIT_MAX);

    localparam logic [RUN_W-1:0] RUN_MIN = RUN_W'(3);

endpackage

// ===== rtl/rle_enc_in_if.sv =====
// ----------------------------------------------------------------------------
// rle_enc_in_if
// Raw byte channel: one byte per transfer, plus an end-of-stream flag.
// ----------------------------------------------------------------------------
interface rle_enc_in_if;
    import rle_enc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              is_final;

    modport source (output valid, output data_byte, output is_final, input ready);
    modport sink   (input valid, input data_byte, input is_final, output ready);

endinterface

// ===== rtl/rle_enc_out_if.sv =====
// ----------------------------------------------------------------------------
// rle_enc_out_if
// Compressed byte channel with burst and stream end markers.
// ----------------------------------------------------------------------------
interface rle_enc_out_if;
    import rle_enc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              burst_end;
    logic              stream_end;

    modport source (output valid, output out_byte, output burst_end, output stream_end,
                    input ready);
    modport sink   (input valid, input out_byte, input burst_end, input stream_end,
                    output ready);

endinterface

// ===== rtl/run_literal_rle_encoder.sv =====
// ----------------------------------------------------------------------------
// run_literal_rle_encoder
// Run/literal byte-stream compressor with a byte-serial output sequencer.
// ----------------------------------------------------------------------------
// Takes one raw byte per input transfer and emits the compressed stream one
// byte per output transfer. A run of 3 to RUN_MAX equal bytes is coded as a
// count byte followed by the repeated byte; other bytes are grouped as a
// negative count (256 - n) followed by n literal bytes, n from 1 to LIT_MAX.
// A byte with is_final set flushes everything pending and the encoder then
// starts a fresh stream. burst_end marks the last output byte caused by one
// input byte, and stream_end the last byte of a final input. An input byte
// is taken only while the sequencer is idle; the single output byte select
// then walks the run bytes, the literal count and the literal store one byte
// per cycle while the output register is free or the sink takes its byte, so
// no new input byte is taken until every output byte it causes has been sent
// to the output register. The output has its own register, so the next input
// byte is taken while the last output byte still waits for the sink. No
// clearing pass runs after reset.
// ----------------------------------------------------------------------------
module run_literal_rle_encoder (
    input  logic          clk,
    input  logic          rst_n,
    rle_enc_in_if.sink    in_ch,
    rle_enc_out_if.source out_ch
);
    import rle_enc_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RUN_CNT  = 3'd1;
    localparam logic [2:0] S_RUN_BYTE = 3'd2;
    localparam logic [2:0] S_LIT_CNT  = 3'd3;
    localparam logic [2:0] S_LIT_DATA = 3'd4;

    localparam logic [CNT_W-1:0] LIT_FULL = CNT_W'(LIT_MAX);
    localparam logic [RUN_W-1:0] RUN_TOP  = RUN_W'(RUN_MAX);

    // encoder state
    logic              started_reg, started_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  lit_reg, lit_next;
    logic [BYTE_W-1:0] store_reg [LIT_MAX];

    // plan for the current burst
    logic              do_run_reg, do_run_next;
    logic              run_first_reg, run_first_next;
    logic [RUN_W-1:0]  rcnt_reg, rcnt_next;
    logic [BYTE_W-1:0] rbyte_reg, rbyte_next;
    logic [CNT_W-1:0]  litn_reg, litn_next;
    logic              fin_reg;

    // sequencer
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    // output register
    logic              ovld_reg;
    logic [BYTE_W-1:0] obyte_reg;
    logic              oburst_reg;
    logic              ostream_reg;

    logic              in_acc;
    logic              emit;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_idx;
    logic [BYTE_W-1:0] x;
    logic [RUN_W-1:0]  run_inc;
    logic [CNT_W-1:0]  lit_inc;

    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;
    logic              lit_last;

    assign x      = in_ch.data_byte;
    assign in_acc = in_ch.valid && in_ch.ready;
    assign emit   = (state_reg != S_IDLE) && (!ovld_reg || out_ch.ready);

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = ovld_reg;
    assign out_ch.out_byte   = obyte_reg;
    assign out_ch.burst_end  = oburst_reg;
    assign out_ch.stream_end = ostream_reg;

    assign lit_inc = lit_reg + CNT_W'(1);

    // ------------------------------------------------------------------
    // Per-byte decision: next encoder state and the burst plan.
    // A burst is at most one run pair and one literal group; run_first
    // says whether the run pair goes out ahead of the literal group.
    // ------------------------------------------------------------------
    always_comb
    begin
        started_next   = started_reg;
        prev_next      = prev_reg;
        run_next       = run_reg;
        lit_next       = lit_reg;
        do_run_next    = 1'b0;
        run_first_next = 1'b0;
        rcnt_next      = run_reg;
        rbyte_next     = prev_reg;
        litn_next      = '0;
        wr_en          = 1'b0;
        wr_idx         = lit_reg;
        run_inc        = run_reg + RUN_W'(1);

        if (!started_reg)
        begin
            // first byte of a stream opens a literal group of one
            started_next = 1'b1;
            prev_next    = x;
            run_next     = RUN_W'(1);
            wr_en        = 1'b1;
            wr_idx       = '0;
            lit_next     = CNT_W'(1);
        end
        else if (x == prev_reg)
        begin
            if (run_inc < RUN_MIN)
            begin
                wr_en = 1'b1;
                if (lit_inc == LIT_FULL)
                begin
                    // full store flushes and restarts the run count
                    litn_next = LIT_FULL;
                    lit_next  = '0;
                    run_inc   = '0;
                end
                else
                begin
                    lit_next = lit_inc;
                end
            end
            else if (run_inc == RUN_MIN)
            begin
                // literals ahead of the two earlier run bytes go out now
                if (lit_reg > CNT_W'(2))
                    litn_next = lit_reg - CNT_W'(2);
                lit_next = '0;
            end
            if (run_inc >= RUN_TOP)
            begin
                do_run_next = 1'b1;
                rcnt_next   = run_inc;
                rbyte_next  = prev_reg;
                run_inc     = '0;
            end
            run_next = run_inc;
        end
        else
        begin
            if (run_reg > RUN_W'(2))
            begin
                do_run_next    = 1'b1;
                run_first_next = 1'b1;
                rcnt_next      = run_reg;
                rbyte_next     = prev_reg;
            end
            wr_en = 1'b1;
            if (lit_inc == LIT_FULL)
            begin
                litn_next = LIT_FULL;
                lit_next  = '0;
                run_next  = '0;
            end
            else
            begin
                lit_next = lit_inc;
                run_next = RUN_W'(1);
            end
            prev_next = x;
        end

        if (in_ch.is_final)
        begin
            if (run_next > RUN_W'(2))
            begin
                do_run_next    = 1'b1;
                run_first_next = 1'b0;
                rcnt_next      = run_next;
                rbyte_next     = prev_next;
            end
            else if (lit_next != '0)
            begin
                litn_next = lit_next;
            end
            started_next = 1'b0;
            prev_next    = '0;
            run_next     = '0;
            lit_next     = '0;
        end
    end

    // ------------------------------------------------------------------
    // Output byte select and sequencing
    // ------------------------------------------------------------------
    assign lit_last = (idx_reg == litn_reg - CNT_W'(1));

    always_comb
    begin
        emit_byte  = rbyte_reg;
        emit_last  = 1'b0;
        state_next = state_reg;
        idx_next   = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next = '0;
                    if (do_run_next && run_first_next)
                        state_next = S_RUN_CNT;
                    else if (litn_next != '0)
                        state_next = S_LIT_CNT;
                    else if (do_run_next)
                        state_next = S_RUN_CNT;
                end
            end
            S_RUN_CNT:
            begin
                emit_byte = {1'b0, rcnt_reg};
                if (emit)
                    state_next = S_RUN_BYTE;
            end
            S_RUN_BYTE:
            begin
                emit_byte = rbyte_reg;
                emit_last = !(run_first_reg && (litn_reg != '0));
                if (emit)
                    state_next = emit_last ? S_IDLE : S_LIT_CNT;
            end
            S_LIT_CNT:
            begin
                // two's complement negative group length
                emit_byte = ~{{(BYTE_W-CNT_W){1'b0}}, litn_reg} + BYTE_W'(1);
                if (emit)
                begin
                    state_next = S_LIT_DATA;
                    idx_next   = '0;
                end
            end
            S_LIT_DATA:
            begin
                emit_byte = store_reg[idx_reg[LIT_IDX_W-1:0]];
                emit_last = lit_last && !(do_run_reg && !run_first_reg);
                if (emit)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    if (lit_last)
                        state_next = emit_last ? S_IDLE : S_RUN_CNT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            prev_reg      <= '0;
            run_reg       <= '0;
            lit_reg       <= '0;
            do_run_reg    <= 1'b0;
            run_first_reg <= 1'b0;
            ovld_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                started_reg   <= started_next;
                prev_reg      <= prev_next;
                run_reg       <= run_next;
                lit_reg       <= lit_next;
                do_run_reg    <= do_run_next;
                run_first_reg <= run_first_next;
            end
            if (emit)
                ovld_reg <= 1'b1;
            else if (out_ch.ready)
                ovld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (in_acc)
        begin
            rcnt_reg  <= rcnt_next;
            rbyte_reg <= rbyte_next;
            litn_reg  <= litn_next;
            fin_reg   <= in_ch.is_final;
            if (wr_en)
                store_reg[wr_idx[LIT_IDX_W-1:0]] <= x;
        end
        if (emit)
        begin
            obyte_reg   <= emit_byte;
            oburst_reg  <= emit_last;
            ostream_reg <= emit_last && fin_reg;
        end
    end

endmodule
